// File: rtl/rxfx_pkg.sv
package rxfx_pkg;

  // Ring geometry; the ring address width matches the payload_start field
  localparam int RING_BYTES = 8192;
  localparam int RING_AW    = $clog2(RING_BYTES);
  localparam int MAX_FRAME  = 1792;

  // Header layout and pointer constants
  localparam int HDR_BYTES  = 4;
  localparam int ALIGN_MASK = 3;
  localparam int CAPR_BIAS  = 16;

  typedef logic [RING_AW-1:0] ring_addr_t;

  // Request commands
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_WRITE = 2'd0;
  localparam cmd_t CMD_POLL  = 2'd1;
  localparam cmd_t CMD_READ  = 2'd2;

  // Result kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_NONE  = 2'd0;
  localparam kind_t KIND_FRAME = 2'd1;
  localparam kind_t KIND_BAD   = 2'd2;
  localparam kind_t KIND_READ  = 2'd3;

endpackage

// File: rtl/rxfx_if.sv
// Request channel: ring writes, ring reads and frame polls
interface rxfx_req_if;
  import rxfx_pkg::*;

  logic        valid;
  logic        ready;
  cmd_t        command;
  logic [13:0] ring_offset;
  logic [7:0]  byte_value;
  logic [15:0] capacity;
  logic        ring_empty;

  modport source (
    output valid, command, ring_offset, byte_value, capacity, ring_empty,
    input  ready
  );
  modport sink (
    input  valid, command, ring_offset, byte_value, capacity, ring_empty,
    output ready
  );
endinterface

// Result channel: poll outcome or read data
interface rxfx_res_if;
  import rxfx_pkg::*;

  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [7:0]  read_data;
  logic [12:0] payload_start;
  logic [10:0] payload_length;
  logic [15:0] capr;
  logic        ack_all;

  modport source (
    output valid, kind, read_data, payload_start, payload_length, capr, ack_all,
    input  ready
  );
  modport sink (
    input  valid, kind, read_data, payload_start, payload_length, capr, ack_all,
    output ready
  );
endinterface

// File: rtl/rxfx_ram.sv
module rxfx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds between reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/rx_ring_frame_extractor.sv
// Receive ring deframer.
// The request channel carries three commands: a ring write stores one byte,
// a ring read returns one byte, and a poll looks for a frame at the current
// read offset. The result channel returns one item per read or poll and
// nothing for a write. The enable register is written through cfg_wr_en and
// cfg_wr_data by the user only while the block is idle; it is not enforced.
// A read returns its byte from the registered ring read port. A poll that
// finds the block disabled, the ring empty or zero capacity skips the ring;
// a full poll passes S_HDR and S_DONE, since the four header bytes come one
// per cycle from the byte-wide ring memory through its single read port.
// Items are handled one at a time: the request side is ready only while the
// block is between items. The result sits in an output register; a new
// request is taken while it waits, and the block holds its next result until
// the receiver takes the previous one.
// Reset clears the read offset, the enable register and the result valid flag.
// The ring contents are not cleared: reading a byte never written is invalid.
module rx_ring_frame_extractor (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  rxfx_req_if.sink   request,
  rxfx_res_if.source result
);
  import rxfx_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_NONE = 3'd2;
  localparam logic [2:0] S_HDR  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]  state;
  logic [1:0]  hdr_idx;
  logic        status_ok;
  logic [7:0]  len_lo;
  logic [15:0] cap;
  ring_addr_t  read_offset;
  logic        enabled;

  logic        res_valid;
  kind_t       res_kind;
  logic [7:0]  res_data;
  ring_addr_t  res_start;
  logic [10:0] res_len;
  logic [15:0] res_capr;
  logic        res_ack;

  logic        accept;
  logic        slot_free;
  logic        poll_none;
  logic        wr_en;
  logic        rd_en;
  ring_addr_t  rd_addr;
  logic [7:0]  rd_data;

  logic [15:0] hdr_len;
  logic        hdr_bad;
  logic [10:0] pay_full;
  logic [10:0] pay_len;
  ring_addr_t  off_sum;
  ring_addr_t  next_off;

  assign request.ready = (state == S_IDLE);
  assign accept        = request.valid && request.ready;
  assign slot_free     = !res_valid || result.ready;
  assign poll_none     = !enabled || (request.capacity == 16'd0) || request.ring_empty;

  // Ring memory ports
  assign wr_en = accept && (request.command == CMD_WRITE);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = read_offset;
    if (state == S_HDR) begin
      rd_en   = 1'b1;
      rd_addr = read_offset + ring_addr_t'(hdr_idx) + ring_addr_t'(1);
    end else if (accept && request.command == CMD_READ) begin
      rd_en   = 1'b1;
      rd_addr = request.ring_offset[RING_AW-1:0];
    end else if (accept && request.command == CMD_POLL && !poll_none) begin
      rd_en   = 1'b1;
      rd_addr = read_offset;
    end
  end

  rxfx_ram #(
    .WIDTH (8),
    .DEPTH (RING_BYTES)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (request.ring_offset[RING_AW-1:0]),
    .wr_data (request.byte_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Header decode; the last length byte is still on the read port in S_DONE
  assign hdr_len  = {rd_data, len_lo};
  assign hdr_bad  = !status_ok || (hdr_len < 16'(HDR_BYTES)) || (hdr_len > 16'(MAX_FRAME));
  assign pay_full = 11'(hdr_len - 16'(HDR_BYTES));
  assign pay_len  = (cap < {5'd0, pay_full}) ? cap[10:0] : pay_full;
  assign off_sum  = read_offset + hdr_len[RING_AW-1:0] + ring_addr_t'(HDR_BYTES + ALIGN_MASK);
  assign next_off = {off_sum[RING_AW-1:2], 2'b00};

  // Enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (cfg_wr_en) begin
      enabled <= cfg_wr_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      hdr_idx     <= 2'd0;
      read_offset <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (request.command)
              CMD_READ: state <= S_READ;
              CMD_POLL: begin
                if (poll_none) begin
                  state <= S_NONE;
                end else begin
                  state   <= S_HDR;
                  hdr_idx <= 2'd0;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_READ, S_NONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        S_HDR: begin
          hdr_idx <= hdr_idx + 2'd1;
          if (hdr_idx == 2'd2) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state       <= S_IDLE;
            read_offset <= hdr_bad ? '0 : next_off;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request payload capture and header bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      cap <= request.capacity;
    end
    if (state == S_HDR && hdr_idx == 2'd0) begin
      status_ok <= rd_data[0];
    end
    if (state == S_HDR && hdr_idx == 2'd2) begin
      len_lo <= rd_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (slot_free && (state inside {S_READ, S_NONE, S_DONE})) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      res_data  <= 8'd0;
      res_start <= '0;
      res_len   <= 11'd0;
      res_capr  <= 16'd0;
      res_ack   <= 1'b0;
      case (state)
        S_READ: begin
          res_kind <= KIND_READ;
          res_data <= rd_data;
        end
        S_NONE: res_kind <= KIND_NONE;
        S_DONE: begin
          if (hdr_bad) begin
            res_kind <= KIND_BAD;
            res_ack  <= 1'b1;
          end else begin
            res_kind  <= KIND_FRAME;
            res_start <= read_offset + ring_addr_t'(HDR_BYTES);
            res_len   <= pay_len;
            res_capr  <= 16'(next_off) - 16'(CAPR_BIAS);
          end
        end
        default: res_kind <= res_kind;
      endcase
    end
  end

  assign result.valid          = res_valid;
  assign result.kind           = res_kind;
  assign result.read_data      = res_data;
  assign result.payload_start  = res_start;
  assign result.payload_length = res_len;
  assign result.capr           = res_capr;
  assign result.ack_all        = res_ack;

endmodule

// File: verif/tb_rx_ring_frame_extractor.sv
module tb_rx_ring_frame_extractor;
  import rxfx_pkg::*;

  // Command code the block ignores
  localparam cmd_t CMD_UNUSED = 2'd3;

  typedef struct packed {
    cmd_t        command;
    logic [13:0] ring_offset;
    logic [7:0]  byte_value;
    logic [15:0] capacity;
    logic        ring_empty;
  } rx_req_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  read_data;
    ring_addr_t  payload_start;
    logic [10:0] payload_length;
    logic [15:0] capr;
    logic        ack_all;
  } rx_res_t;

  // One request item and the result it should produce, if any
  typedef struct packed {
    rx_req_t req;
    bit      has_res;
    rx_res_t res;
  } req_item_t;

  typedef enum int {RDY_ALWAYS, RDY_THREE_IN_FOUR, RDY_COIN, RDY_ONE_IN_EIGHT} rdy_pattern_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  rxfx_req_if req_ch ();
  rxfx_res_if res_ch ();

  rx_ring_frame_extractor u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .request     (req_ch),
    .result      (res_ch)
  );

  always #5 clk = ~clk;

  // Shadow of the ring, read pointer and enable bit
  logic [7:0] ring_mem [RING_BYTES];
  bit         ring_written [RING_BYTES];
  ring_addr_t written_list [$];
  ring_addr_t ring_rd_ptr = '0;
  bit         rx_enabled = 1'b0;

  req_item_t  pending_reqs [$];
  rx_res_t    due_results [$];
  req_item_t  on_wire;
  bit         req_taken = 1'b0;
  int         reqs_queued = 0;
  int         reqs_taken = 0;
  int         fault_count = 0;

  // Sender burst/gap state and receiver stall pattern
  int           burst_left = 1;
  int           send_gap = 0;
  rdy_pattern_t rdy_mode = RDY_ALWAYS;
  int           rdy_span = 0;
  int           rdy_tick = 0;

  // Apply one request to the shadow state; returns 1 when a result is due
  function automatic bit deframe_step(input rx_req_t r, output rx_res_t res);
    ring_addr_t  a;
    ring_addr_t  base;
    logic [15:0] status;
    logic [15:0] len_crc;
    logic [15:0] pay;
    int          nxt;
    res  = '0;
    a    = r.ring_offset[RING_AW-1:0];
    base = ring_rd_ptr;
    if (r.command == CMD_WRITE) begin
      ring_mem[a] = r.byte_value;
      return 1'b0;
    end
    if (r.command == CMD_READ) begin
      res.kind      = KIND_READ;
      res.read_data = ring_mem[a];
      return 1'b1;
    end
    if (r.command != CMD_POLL) return 1'b0;
    if (!rx_enabled || r.capacity == 16'd0 || r.ring_empty) begin
      res.kind = KIND_NONE;
      return 1'b1;
    end
    // little-endian header: status word, then length incl. CRC
    status  = {ring_mem[ring_addr_t'(base + 1)], ring_mem[base]};
    len_crc = {ring_mem[ring_addr_t'(base + 3)], ring_mem[ring_addr_t'(base + 2)]};
    if (!status[0] || len_crc < HDR_BYTES || len_crc > MAX_FRAME) begin
      ring_rd_ptr = '0;
      res.kind    = KIND_BAD;
      res.ack_all = 1'b1;
      return 1'b1;
    end
    pay = len_crc - HDR_BYTES;
    if (pay > r.capacity) pay = r.capacity;
    // skip header and frame, dword aligned, wrapped to the ring
    nxt = (int'(base) + int'(len_crc) + HDR_BYTES + ALIGN_MASK) & ~ALIGN_MASK;
    ring_rd_ptr = ring_addr_t'(nxt);
    res.kind           = KIND_FRAME;
    res.payload_start  = ring_addr_t'(base + HDR_BYTES);
    res.payload_length = pay[10:0];
    res.capr           = 16'(int'(ring_rd_ptr) - CAPR_BIAS);
    return 1'b1;
  endfunction

  function automatic logic [13:0] alias_addr(ring_addr_t a);
    return {1'($urandom_range(0, 1)), a};
  endfunction

  // Frame length incl. CRC: mostly short, some long, some at the limits
  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return 16'($urandom_range(HDR_BYTES, 68));
    if (r < 18) return 16'($urandom_range(69, MAX_FRAME));
    case ($urandom_range(0, 3))
      0:       return 16'(HDR_BYTES);
      1:       return 16'(HDR_BYTES + 1);
      2:       return 16'(MAX_FRAME - 1);
      default: return 16'(MAX_FRAME);
    endcase
  endfunction

  // Consumer capacity, sometimes below the payload so it clamps
  function automatic logic [15:0] pick_capacity(logic [15:0] len);
    int r;
    int pay;
    r   = $urandom_range(0, 19);
    pay = int'(len) - HDR_BYTES;
    if (r < 11) return 16'($urandom_range(1, 65535));
    if (r < 16) return 16'($urandom_range(1, (pay < 1) ? 1 : pay));
    if (r < 18) return 16'd1;
    return 16'hFFFF;
  endfunction

  task automatic queue_req(cmd_t c, logic [13:0] off, logic [7:0] b, logic [15:0] cap,
                           logic e);
    req_item_t s;
    s.req.command      = c;
    s.req.ring_offset  = off;
    s.req.byte_value   = b;
    s.req.capacity     = cap;
    s.req.ring_empty   = e;
    s.has_res = deframe_step(s.req, s.res);
    pending_reqs.push_back(s);
    reqs_queued++;
  endtask

  task automatic put_byte(logic [13:0] off, logic [7:0] v);
    ring_addr_t a;
    a = off[RING_AW-1:0];
    if (!ring_written[a]) begin
      ring_written[a] = 1'b1;
      written_list.push_back(a);
    end
    queue_req(CMD_WRITE, off, v, 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Read back a byte that is known to be written
  task automatic get_byte();
    ring_addr_t a;
    a = written_list[$urandom_range(0, written_list.size() - 1)];
    queue_req(CMD_READ, alias_addr(a), 8'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic poll(logic [15:0] cap, logic e);
    queue_req(CMD_POLL, 14'($urandom), 8'($urandom), cap, e);
  endtask

  // Header bytes at the read pointer, in a rotated order
  task automatic put_header(logic [15:0] status, logic [15:0] len);
    ring_addr_t  base;
    logic [31:0] hdr;
    int          k0;
    int          j;
    base = ring_rd_ptr;
    hdr  = {len, status};
    k0   = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) begin
      j = (k0 + i) % 4;
      put_byte(alias_addr(ring_addr_t'(base + j)), hdr[8*j +: 8]);
    end
  endtask

  task automatic good_frame(logic [15:0] len, logic [15:0] cap);
    ring_addr_t base;
    int         extra;
    base = ring_rd_ptr;
    put_header(16'($urandom) | 16'h0001, len);
    extra = $urandom_range(0, 3);
    for (int i = 0; i < extra; i++)
      put_byte(alias_addr(ring_addr_t'(base + HDR_BYTES + i)), 8'($urandom));
    if ($urandom_range(0, 3) == 0) get_byte();
    poll(cap, 1'b0);
  endtask

  // Walk the pointer to the last dword of the ring, then wrap past it
  task automatic chase_ring_end();
    int         span;
    logic [15:0] len;
    span = RING_BYTES - HDR_BYTES - int'(ring_rd_ptr);
    while (span > MAX_FRAME + HDR_BYTES || span < 8) begin
      good_frame(16'(MAX_FRAME), 16'hFFFF);
      span = RING_BYTES - HDR_BYTES - int'(ring_rd_ptr);
    end
    len = 16'(span - HDR_BYTES);
    good_frame(len, pick_capacity(len));
    len = 16'($urandom_range(HDR_BYTES, 12));
    good_frame(len, pick_capacity(len));
  endtask

  task automatic run_scenario();
    int          r;
    int          r2;
    logic [15:0] len;
    ring_addr_t  base;
    bit          stale;
    r    = $urandom_range(0, 99);
    r2   = $urandom_range(0, 2);
    base = ring_rd_ptr;
    if (r < 55) begin
      len = pick_length();
      good_frame(len, pick_capacity(len));
    end else if (r < 67) begin
      // broken header: status bit clear, too short, too long
      if (r2 == 0)
        put_header(16'($urandom) & 16'hFFFE, 16'($urandom_range(HDR_BYTES, MAX_FRAME)));
      else if (r2 == 1)
        put_header(16'($urandom) | 16'h0001, 16'($urandom_range(0, HDR_BYTES - 1)));
      else
        put_header(16'($urandom) | 16'h0001, 16'($urandom_range(MAX_FRAME + 1, 65535)));
      poll(16'($urandom_range(1, 65535)), 1'b0);
    end else if (r < 77) begin
      // empty ring, zero capacity, or a poll on whatever header sits there
      stale = ring_written[base] && ring_written[ring_addr_t'(base + 1)] &&
              ring_written[ring_addr_t'(base + 2)] && ring_written[ring_addr_t'(base + 3)];
      if (r2 == 0)
        poll(16'($urandom), 1'b1);
      else if (r2 == 1)
        poll(16'h0000, 1'($urandom_range(0, 1)));
      else
        poll(16'($urandom_range(1, 65535)), stale ? 1'b0 : 1'b1);
    end else if (r < 87) begin
      put_byte(alias_addr(ring_addr_t'($urandom)), 8'($urandom));
    end else if (r < 95) begin
      get_byte();
    end else begin
      queue_req(CMD_UNUSED, 14'($urandom), 8'($urandom), 16'($urandom),
                1'($urandom_range(0, 1)));
    end
  endtask

  // Hold off until every item is taken and every result is back
  task automatic wait_idle();
    while (!(reqs_taken == reqs_queued && due_results.size() == 0)) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic cfg_write(bit v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    rx_enabled = v;
  endtask

  // Request driver: bursts of items with random gaps
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        on_wire = pending_reqs.pop_front();
        req_ch.valid        <= 1'b1;
        req_ch.command      <= on_wire.req.command;
        req_ch.ring_offset  <= on_wire.req.ring_offset;
        req_ch.byte_value   <= on_wire.req.byte_value;
        req_ch.capacity     <= on_wire.req.capacity;
        req_ch.ring_empty   <= on_wire.req.ring_empty;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          send_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: ready follows a stall pattern that is picked anew at random
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (rdy_span == 0) begin
        rdy_mode = rdy_pattern_t'($urandom_range(0, 3));
        rdy_span = $urandom_range(20, 200);
      end
      rdy_span--;
      rdy_tick++;
      case (rdy_mode)
        RDY_ALWAYS:        res_ch.ready <= 1'b1;
        RDY_THREE_IN_FOUR: res_ch.ready <= (rdy_tick[1:0] != 2'd3);
        RDY_COIN:          res_ch.ready <= 1'($urandom_range(0, 1));
        default:           res_ch.ready <= (rdy_tick[2:0] == 3'd0);
      endcase
    end
  end

  // Result check first, then record the request taken on this edge
  always @(posedge clk) begin
    rx_res_t got;
    rx_res_t want;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        got.kind           = res_ch.kind;
        got.read_data      = res_ch.read_data;
        got.payload_start  = res_ch.payload_start;
        got.payload_length = res_ch.payload_length;
        got.capr           = res_ch.capr;
        got.ack_all        = res_ch.ack_all;
        if (due_results.size() == 0) begin
          $error("unexpected result item: kind %0d", got.kind);
          fault_count++;
        end else begin
          want = due_results.pop_front();
          if (got.kind != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            fault_count++;
          end
          if (got.read_data != want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
            fault_count++;
          end
          if (got.payload_start != want.payload_start) begin
            $error("payload_start: expected %0d, got %0d", want.payload_start,
                   got.payload_start);
            fault_count++;
          end
          if (got.payload_length != want.payload_length) begin
            $error("payload_length: expected %0d, got %0d", want.payload_length,
                   got.payload_length);
            fault_count++;
          end
          if (got.capr != want.capr) begin
            $error("capr: expected %0h, got %0h", want.capr, got.capr);
            fault_count++;
          end
          if (got.ack_all != want.ack_all) begin
            $error("ack_all: expected %0d, got %0d", want.ack_all, got.ack_all);
            fault_count++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        req_taken = 1'b1;
        reqs_taken++;
        if (on_wire.has_res) due_results.push_back(on_wire.res);
      end
    end
  end

  // Stimulus: directed opening, then random phases
  initial begin
    bit phase_en [5];
    int phase_len [5];
    int goal;
    phase_en  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    phase_len = '{450, 120, 450, 350, 330};
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.command      = CMD_WRITE;
    req_ch.ring_offset  = '0;
    req_ch.byte_value   = '0;
    req_ch.capacity     = '0;
    req_ch.ring_empty   = 1'b0;
    res_ch.ready        = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // disabled: writes still land, polls find nothing, command 3 is dropped
    cfg_write(1'b0);
    put_byte(14'h3FFF, 8'hFF);
    queue_req(CMD_READ, 14'h1FFF, 8'h00, 16'h0000, 1'b0);
    put_header(16'h0001, 16'd64);
    poll(16'hFFFF, 1'b0);
    queue_req(CMD_UNUSED, 14'h3FFF, 8'hFF, 16'hFFFF, 1'b1);
    wait_idle();

    // enabled: empty ring, zero capacity, clamped and full-size frames, bad headers
    cfg_write(1'b1);
    poll(16'hFFFF, 1'b1);
    poll(16'h0000, 1'b0);
    poll(16'h0001, 1'b0);
    put_header(16'hFFFF, 16'(MAX_FRAME));
    poll(16'hFFFF, 1'b0);
    put_header(16'hFFFE, 16'(HDR_BYTES));
    poll(16'hFFFF, 1'b0);
    put_header(16'h0001, 16'd3);
    poll(16'hFFFF, 1'b0);

    for (int p = 0; p < 5; p++) begin
      wait_idle();
      cfg_write(phase_en[p]);
      goal = reqs_queued + phase_len[p];
      if (phase_en[p] && p >= 2) chase_ring_end();
      while (reqs_queued < goal) run_scenario();
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (fault_count == 0)
      $display("rx_ring_frame_extractor: match");
    else
      $display("rx_ring_frame_extractor: mismatch");
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("rx_ring_frame_extractor: mismatch");
    $finish;
  end

endmodule
